// ===== sv/line_frame_averager_top_macros.svh =====
// Assertion macros shared by the line frame averager RTL.
`ifndef LINE_FRAME_AVERAGER_TOP_MACROS_SVH
`define LINE_FRAME_AVERAGER_TOP_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define LFA_ASSERT_NOW(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error("line frame averager: same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define LFA_ASSERT_NEXT(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error("line frame averager: next-cycle check failed");

`endif

// ===== sv/lfa_pkg.sv =====
// Types and constants of the line frame averager.
package lfa_pkg;

   localparam int PIXEL_W = 12;
   localparam int CFG_W   = 8;
   localparam int COUNT_W = 8;

   typedef enum logic [1:0] {
      MODE_PASS = 2'd0,
      MODE_COPY = 2'd1,
      MODE_AVG  = 2'd2,
      MODE_SEND = 2'd3
   } frame_mode_type;

   typedef struct packed {
      logic [PIXEL_W-1:0] pixel_value;
      logic               last_pixel;
      logic               link_busy;
   } req_payload_type;

   typedef struct packed {
      logic [PIXEL_W-1:0] pixel_out;
      logic               line_end;
   } rsp_payload_type;

endpackage

// ===== sv/line_frame_averager_top.sv =====
// Line frame averager: recursive averaging of line-sensor frames over one line store.
`include "line_frame_averager_top_macros.svh"

// The block takes one pixel transfer per clock cycle on the req_ channel when
// req_ready is high, giving at most one rsp_ transfer for each. What happens
// to a frame is settled at its first pixel: with frames_to_average at 1 the
// pixels pass straight through (or the whole frame is dropped if link_busy is
// set at the first pixel); otherwise the frame is copied into the line store
// when the frame counter is zero, averaged into it as floor(new/2)+floor(old/2)
// while the count is not yet reached or the link is busy, and else the stored
// line is sent while the incoming frame is discarded. A frame ends at a pixel
// marked last_pixel or at index PIXELS-1, whichever comes first. Each pixel
// goes from acceptance through the registered read of the line store to the
// average write-back or the output register. The sustained rate is one pixel
// per cycle when the output is not stalled, set by the single read-modify-write
// of the store per pixel; a write-back that meets a read of the same entry in
// the same cycle is forwarded. req_ready depends combinationally on rsp_ready
// when a result is waiting in the output register. The line store is not
// cleared after reset; an entry must be written by a copy frame before it is
// averaged or sent. The csr_ port writes frames_to_average and is always
// ready; a new value takes effect at the next frame's first pixel.
module line_frame_averager_top #(
   parameter int PIXELS = 4096
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  lfa_pkg::req_payload_type      req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output lfa_pkg::rsp_payload_type      rsp_data,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [lfa_pkg::CFG_W-1:0]     csr_data
);

   localparam int IDX_W = (PIXELS > 1) ? $clog2(PIXELS) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PIXELS - 1);

   // Configuration register.
   logic [lfa_pkg::CFG_W-1:0]   frames_to_average_ff;

   // Frame state, updated at each accepted pixel.
   logic [IDX_W-1:0]            pixel_index_ff, pixel_index_in;
   lfa_pkg::frame_mode_type     frame_mode_ff, frame_mode_in;
   logic                        frame_skip_ff, frame_skip_in;
   logic [lfa_pkg::COUNT_W-1:0] frame_count_ff, frame_count_in;

   // Second stage: the accepted pixel waiting for its store read.
   logic                        s1_valid_ff, s1_valid_in;
   lfa_pkg::frame_mode_type     s1_mode_ff;
   logic                        s1_skip_ff;
   logic                        s1_end_ff;
   logic [lfa_pkg::PIXEL_W-1:0] s1_pixel_ff;
   logic [IDX_W-1:0]            s1_idx_ff;

   // Line store and its registered read, with a forwarding path.
   logic [lfa_pkg::PIXEL_W-1:0] store_mem [PIXELS];
   logic [lfa_pkg::PIXEL_W-1:0] mem_rd_ff;
   logic                        fwd_ff;
   logic [lfa_pkg::PIXEL_W-1:0] fwd_data_ff;

   // Output register.
   logic                        rsp_valid_ff, rsp_valid_in;
   lfa_pkg::rsp_payload_type    rsp_data_ff;

   logic                        req_accept;
   logic                        first_pixel;
   logic                        frame_end;
   lfa_pkg::frame_mode_type     mode_now;
   logic                        skip_now;
   logic [lfa_pkg::COUNT_W:0]   count_plus_one;

   logic                        s1_emit;
   logic                        s1_moves;
   logic                        rsp_load;
   logic                        mem_we;
   logic [lfa_pkg::PIXEL_W-1:0] old_pixel;
   logic [lfa_pkg::PIXEL_W-1:0] avg_pixel;
   logic [lfa_pkg::PIXEL_W-1:0] wr_data;

   assign csr_ready = 1'b1;

   // ---------------------------------------------------------------------
   // Stage handshake. The second stage always drains when its pixel gives no
   // result, as a store update or a dropped pixel; a pixel with a result waits
   // for the output register to be free or to be emptied in the same cycle.
   // ---------------------------------------------------------------------
   assign s1_emit  = ((s1_mode_ff == lfa_pkg::MODE_PASS) && !s1_skip_ff) ||
                     (s1_mode_ff == lfa_pkg::MODE_SEND);
   assign s1_moves = s1_valid_ff && (!s1_emit || !rsp_valid_ff || rsp_ready);
   assign req_ready  = !s1_valid_ff || s1_moves;
   assign req_accept = req_valid && req_ready;
   assign rsp_load   = s1_moves && s1_emit;
   assign mem_we     = s1_moves && ((s1_mode_ff == lfa_pkg::MODE_COPY) ||
                                    (s1_mode_ff == lfa_pkg::MODE_AVG));

   // ---------------------------------------------------------------------
   // Frame mode decision and frame state update for the accepted pixel.
   // ---------------------------------------------------------------------
   assign first_pixel    = (pixel_index_ff == '0);
   assign frame_end      = req_data.last_pixel || (pixel_index_ff == LAST_IDX);
   assign count_plus_one = {1'b0, frame_count_ff} + 1'b1;

   always_comb begin
      mode_now = frame_mode_ff;
      skip_now = frame_skip_ff;
      if (first_pixel) begin
         skip_now = 1'b0;
         if (frames_to_average_ff == lfa_pkg::CFG_W'(1)) begin
            mode_now = lfa_pkg::MODE_PASS;
            skip_now = req_data.link_busy;
         end else if (frame_count_ff == '0) begin
            mode_now = lfa_pkg::MODE_COPY;
         end else if ((count_plus_one < {1'b0, frames_to_average_ff}) ||
                      req_data.link_busy) begin
            mode_now = lfa_pkg::MODE_AVG;
         end else begin
            mode_now = lfa_pkg::MODE_SEND;
         end
      end
   end

   always_comb begin
      pixel_index_in = pixel_index_ff;
      frame_mode_in  = frame_mode_ff;
      frame_skip_in  = frame_skip_ff;
      frame_count_in = frame_count_ff;
      if (req_accept) begin
         frame_mode_in = mode_now;
         frame_skip_in = skip_now;
         if (frame_end) begin
            pixel_index_in = '0;
            unique case (mode_now)
               lfa_pkg::MODE_COPY,
               lfa_pkg::MODE_AVG:  frame_count_in = frame_count_ff + 1'b1;
               lfa_pkg::MODE_SEND: frame_count_in = '0;
               default:            frame_count_in = frame_count_ff;
            endcase
         end else begin
            pixel_index_in = pixel_index_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frames_to_average_ff <= lfa_pkg::CFG_W'(1);
         pixel_index_ff       <= '0;
         frame_mode_ff        <= lfa_pkg::MODE_PASS;
         frame_skip_ff        <= 1'b0;
         frame_count_ff       <= '0;
      end else begin
         if (csr_valid && csr_ready) begin
            frames_to_average_ff <= csr_data;
         end
         pixel_index_ff <= pixel_index_in;
         frame_mode_ff  <= frame_mode_in;
         frame_skip_ff  <= frame_skip_in;
         frame_count_ff <= frame_count_in;
      end
   end

   // ---------------------------------------------------------------------
   // Second stage registers.
   // ---------------------------------------------------------------------
   assign s1_valid_in = req_accept || (s1_valid_ff && !s1_moves);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_mode_ff  <= mode_now;
         s1_skip_ff  <= skip_now;
         s1_end_ff   <= frame_end;
         s1_pixel_ff <= req_data.pixel_value;
         s1_idx_ff   <= pixel_index_ff;
         // A write-back to the entry being read in this same cycle is not yet
         // in the memory, so its data is carried alongside the read.
         fwd_ff      <= mem_we && (s1_idx_ff == pixel_index_ff);
         fwd_data_ff <= wr_data;
      end
   end

   // Line store: one read and one write per cycle.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         mem_rd_ff <= store_mem[pixel_index_ff];
      end
      if (mem_we) begin
         store_mem[s1_idx_ff] <= wr_data;
      end
   end

   assign old_pixel = fwd_ff ? fwd_data_ff : mem_rd_ff;
   assign avg_pixel = (s1_pixel_ff >> 1) + (old_pixel >> 1);
   assign wr_data   = (s1_mode_ff == lfa_pkg::MODE_COPY) ? s1_pixel_ff : avg_pixel;

   // ---------------------------------------------------------------------
   // Output register.
   // ---------------------------------------------------------------------
   assign rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_data_ff.pixel_out <= (s1_mode_ff == lfa_pkg::MODE_SEND) ? old_pixel
                                                                     : s1_pixel_ff;
         rsp_data_ff.line_end  <= s1_end_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // ---------------------------------------------------------------------
   // Assertions.
   // ---------------------------------------------------------------------
   // A pixel that only updates the store never holds up the second stage.
   `LFA_ASSERT_NOW(a_store_update_drains, clock, reset, s1_valid_ff && !s1_emit, s1_moves)
   // A store write and an output load never come from the same pixel.
   `LFA_ASSERT_NOW(a_write_or_send, clock, reset, mem_we, !rsp_load)
   // The last pixel of a sent line clears the frame counter.
   `LFA_ASSERT_NEXT(a_send_clears_count, clock, reset,
      req_accept && frame_end && (mode_now == lfa_pkg::MODE_SEND), frame_count_ff == '0)
   // A frame end always returns the pixel index to the start of the line.
   `LFA_ASSERT_NEXT(a_end_rewinds_index, clock, reset,
      req_accept && frame_end, pixel_index_ff == '0)

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the line frame averager, with directed and random pixel frames.

// Shadow of the averager: its own line store, frame counter and setting. It works out
// the pixel that each accepted pixel should produce and keeps those pixels until the
// block returns them.
class averaged_line_shadow #(int PIXELS = 4096);
   bit [lfa_pkg::PIXEL_W-1:0]  line_store [PIXELS];
   bit [lfa_pkg::COUNT_W-1:0]  frame_count;
   bit [lfa_pkg::CFG_W-1:0]    frames_to_average;
   int unsigned                pixel_index;
   lfa_pkg::frame_mode_type    mode;
   bit                         drop_frame;
   int unsigned                written_len;
   lfa_pkg::rsp_payload_type   expected_pixels [$];
   int unsigned                mismatches;
   int unsigned                checked;

   function new();
      frames_to_average = 1;
      frame_count = '0;
      pixel_index = 0;
      mode = lfa_pkg::MODE_PASS;
      drop_frame = 1'b0;
      written_len = 0;
      mismatches = 0;
      checked = 0;
   endfunction

   function void set_frames(bit [lfa_pkg::CFG_W-1:0] value);
      frames_to_average = value;
   endfunction

   function int pending();
      return expected_pixels.size();
   endfunction

   // The mode that a frame opening now would take with this busy flag.
   function lfa_pkg::frame_mode_type mode_at_start(bit busy);
      if (frames_to_average == 1)
         return lfa_pkg::MODE_PASS;
      if (frame_count == 0)
         return lfa_pkg::MODE_COPY;
      if (int'(frame_count) + 1 < int'(frames_to_average) || busy)
         return lfa_pkg::MODE_AVG;
      return lfa_pkg::MODE_SEND;
   endfunction

   function void note_pixel(lfa_pkg::req_payload_type px);
      bit                       line_done;
      lfa_pkg::rsp_payload_type outcome;
      if (pixel_index == 0) begin
         mode = mode_at_start(px.link_busy);
         drop_frame = (mode == lfa_pkg::MODE_PASS) && px.link_busy;
      end
      line_done = px.last_pixel || pixel_index == PIXELS - 1;
      case (mode)
         lfa_pkg::MODE_PASS: begin
            if (!drop_frame) begin
               outcome.pixel_out = px.pixel_value;
               outcome.line_end = line_done;
               expected_pixels.push_back(outcome);
            end
         end
         lfa_pkg::MODE_COPY: begin
            line_store[pixel_index] = px.pixel_value;
            if (pixel_index + 1 > written_len)
               written_len = pixel_index + 1;
         end
         lfa_pkg::MODE_AVG: begin
            line_store[pixel_index] = (px.pixel_value >> 1) + (line_store[pixel_index] >> 1);
         end
         lfa_pkg::MODE_SEND: begin
            outcome.pixel_out = line_store[pixel_index];
            outcome.line_end = line_done;
            expected_pixels.push_back(outcome);
         end
      endcase
      if (line_done) begin
         if (mode == lfa_pkg::MODE_COPY || mode == lfa_pkg::MODE_AVG)
            frame_count = frame_count + 1'b1;
         else if (mode == lfa_pkg::MODE_SEND)
            frame_count = '0;
         pixel_index = 0;
      end else begin
         pixel_index = pixel_index + 1;
      end
   endfunction

   task report(string what);
      mismatches++;
      $display("MISMATCH %0d at %0t: %s", mismatches, $time, what);
   endtask

   task check_pixel(lfa_pkg::rsp_payload_type got);
      lfa_pkg::rsp_payload_type want;
      if (expected_pixels.size() == 0) begin
         report($sformatf("result with nothing outstanding: pixel_out=%0d line_end=%0b",
                          got.pixel_out, got.line_end));
         return;
      end
      want = expected_pixels.pop_front();
      checked++;
      if (got.pixel_out !== want.pixel_out)
         report($sformatf("pixel_out %0d, expected %0d", got.pixel_out, want.pixel_out));
      if (got.line_end !== want.line_end)
         report($sformatf("line_end %0b, expected %0b", got.line_end, want.line_end));
   endtask
endclass

module testbench;

   localparam int     LINE_PIXELS   = 4096;
   localparam int     RANDOM_PIXELS = 1400;
   localparam int     MAX_GAP       = 19;
   // Extra cycles after the last result so that a pixel that gives no result can finish.
   localparam int     SETTLE_CYCLES = 8;
   localparam longint CYCLE_LIMIT   = 2_000_000;

   logic                         clock;
   logic                         reset;
   logic                         req_valid;
   logic                         req_ready;
   lfa_pkg::req_payload_type     req_data;
   logic                         rsp_valid;
   logic                         rsp_ready;
   lfa_pkg::rsp_payload_type     rsp_data;
   logic                         csr_valid;
   logic                         csr_ready;
   logic [lfa_pkg::CFG_W-1:0]    csr_data;

   averaged_line_shadow #(LINE_PIXELS) shadow;

   longint unsigned cycle_count = 0;
   int unsigned     pixels_fed = 0;
   int unsigned     frames_fed = 0;
   int unsigned     settings_written = 0;

   // Calm stretches switch idling off on one side.
   bit req_calm = 1'b0;
   bit rsp_calm = 1'b0;

   line_frame_averager_top #(
      .PIXELS(LINE_PIXELS)
   ) u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_data (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Watchdog: a correct run ends long before this.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Timed out after %0d cycles with %0d results outstanding.",
                  cycle_count, shadow.pending());
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // Every result transfer is checked against the oldest outstanding pixel.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         shadow.check_pixel(rsp_data);
   end

   function automatic int next_req_gap();
      if ($urandom_range(0, 63) == 0)
         req_calm = !req_calm;
      if (req_calm)
         return 0;
      return $urandom_range(0, MAX_GAP);
   endfunction

   function automatic int next_rsp_gap();
      if ($urandom_range(0, 63) == 0)
         rsp_calm = !rsp_calm;
      if (rsp_calm)
         return 0;
      return $urandom_range(0, MAX_GAP);
   endfunction

   function automatic bit [lfa_pkg::PIXEL_W-1:0] pick_pixel();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         default: return lfa_pkg::PIXEL_W'($urandom_range(0, (1 << lfa_pkg::PIXEL_W) - 1));
      endcase
   endfunction

   // Settings lean towards small counts so that lines are sent often, with the
   // extremes and the never-reached zero mixed in.
   function automatic bit [lfa_pkg::CFG_W-1:0] pick_setting();
      case ($urandom_range(0, 9))
         0, 1: return lfa_pkg::CFG_W'(1);
         2: return '0;
         3: return '1;
         4: return lfa_pkg::CFG_W'($urandom_range(0, (1 << lfa_pkg::CFG_W) - 1));
         default: return lfa_pkg::CFG_W'($urandom_range(2, 6));
      endcase
   endfunction

   // Receiver: before each result transfer it holds rsp_ready low for a drawn number
   // of cycles, then keeps it high until the transfer happens.
   initial begin
      int stall;
      rsp_ready = 1'b0;
      wait (reset === 1'b0);
      forever begin
         stall = next_rsp_gap();
         if (stall > 0) begin
            @(negedge clock);
            rsp_ready <= 1'b0;
            repeat (stall - 1) @(negedge clock);
         end
         @(negedge clock);
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!(rsp_valid && rsp_ready)) @(posedge clock);
      end
   end

   // One pixel transfer. req_valid stays high from one pixel to the next when no gap
   // is drawn; settle() lowers it whenever the sender stops.
   task automatic feed_pixel(bit [lfa_pkg::PIXEL_W-1:0] value, bit last, bit busy);
      lfa_pkg::req_payload_type px;
      int                       gap;
      px.pixel_value = value;
      px.last_pixel = last;
      px.link_busy = busy;
      gap = next_req_gap();
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_data <= px;
      @(posedge clock);
      while (!(req_valid && req_ready)) @(posedge clock);
      shadow.note_pixel(px);
      pixels_fed++;
   endtask

   // Stops the sender and waits until every outstanding result has arrived and the
   // pipeline has had time to finish any pixel that gives no result.
   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (shadow.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_frames(bit [lfa_pkg::CFG_W-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data <= value;
      @(posedge clock);
      while (!(csr_valid && csr_ready)) @(posedge clock);
      shadow.set_frames(value);
      settings_written++;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // One frame of random pixels. A frame that averages into the store or sends from it
   // is cut to the part of the store written since reset. With cfg_at above zero, the
   // sender stops after that many pixels, lets the block go quiet and writes cfg_value.
   task automatic feed_frame(int len, bit busy, bit mark_last, int cfg_at,
                             bit [lfa_pkg::CFG_W-1:0] cfg_value);
      lfa_pkg::frame_mode_type plan;
      int                      count;
      plan = shadow.mode_at_start(busy);
      count = len;
      if ((plan == lfa_pkg::MODE_AVG || plan == lfa_pkg::MODE_SEND) &&
          count > int'(shadow.written_len))
         count = shadow.written_len;
      for (int i = 0; i < count; i++) begin
         if (cfg_at > 0 && i == cfg_at) begin
            settle();
            write_frames(cfg_value);
         end
         feed_pixel(pick_pixel(), mark_last && i == count - 1,
                    (i == 0) ? busy : 1'($urandom_range(0, 1)));
      end
      frames_fed++;
   endtask

   initial begin
      int unsigned random_goal;
      int          len;
      int          cfg_at;
      shadow = new();
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_valid = 1'b0;
      csr_data = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // The reset setting is 1, so pixels pass straight through.
      feed_pixel('0, 1'b0, 1'b0);
      feed_pixel('1, 1'b0, 1'b1);
      feed_pixel(12'hAAA, 1'b0, 1'b0);
      feed_pixel(12'h555, 1'b1, 1'b1);
      // A busy link at the first pixel drops the whole pass-through frame.
      feed_pixel(12'h123, 1'b0, 1'b1);
      feed_pixel(12'h456, 1'b1, 1'b0);
      frames_fed += 2;

      // Copy, average, average forced by a busy link, then send the stored line.
      settle();
      write_frames(8'd3);
      feed_pixel('1, 1'b0, 1'b0);
      feed_pixel('1, 1'b0, 1'b0);
      feed_pixel(12'h001, 1'b0, 1'b0);
      feed_pixel('0, 1'b1, 1'b0);
      feed_pixel('1, 1'b0, 1'b0);
      feed_pixel('0, 1'b0, 1'b0);
      feed_pixel('1, 1'b0, 1'b0);
      feed_pixel(12'h001, 1'b1, 1'b0);
      frames_fed += 2;
      feed_frame(4, 1'b1, 1'b1, -1, '0);
      feed_frame(4, 1'b0, 1'b1, -1, '0);

      // A setting written in the middle of a frame applies from the next frame on.
      settle();
      write_frames(8'd2);
      feed_frame(4, 1'b0, 1'b1, 2, 8'd1);
      feed_frame(3, 1'b0, 1'b1, -1, '0);
      settle();
      write_frames(8'd2);
      feed_frame(4, 1'b0, 1'b1, -1, '0);

      // A setting of zero is never reached: average while busy, send otherwise.
      settle();
      write_frames('0);
      feed_frame(3, 1'b0, 1'b1, -1, '0);
      feed_frame(3, 1'b1, 1'b1, -1, '0);
      feed_frame(3, 1'b0, 1'b1, -1, '0);

      // Busy single-pixel frames walk the frame counter through its wrap to zero,
      // after which the next frame is copied again.
      repeat (257) feed_frame(1, 1'b1, 1'b1, -1, '0);

      // Random phases: each starts from a quiet block with a fresh setting and feeds
      // well-formed frames of random content, now and then with a mid-frame write.
      random_goal = pixels_fed + RANDOM_PIXELS;
      while (pixels_fed < random_goal) begin
         settle();
         write_frames(pick_setting());
         repeat ($urandom_range(4, 24)) begin
            if ($urandom_range(0, 9) == 0)
               len = $urandom_range(17, 80);
            else
               len = $urandom_range(1, 16);
            cfg_at = ($urandom_range(0, 9) == 0) ? $urandom_range(1, len) : -1;
            feed_frame(len, $urandom_range(0, 3) == 0, 1'b1, cfg_at, pick_setting());
         end
      end

      settle();
      $display("Covered %0d pixel transfers in %0d frames and %0d setting writes;",
               pixels_fed, frames_fed, settings_written);
      $display("checked %0d result transfers, including counter wrap and mid-frame writes.",
               shadow.checked);
      if (shadow.mismatches == 0 && shadow.pending() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
